// File: design/agu_pkg.sv
// Package: shared types, mode codes and Q16.16 constants for the activation unit.
`timescale 1ns / 1ps

package agu_pkg;

    typedef logic [4:0] t_mode;

    localparam t_mode MODE_LINEAR   = 5'd0;
    localparam t_mode MODE_LOGISTIC = 5'd1;
    localparam t_mode MODE_LOGGY    = 5'd2;
    localparam t_mode MODE_RELU     = 5'd3;
    localparam t_mode MODE_RELU6    = 5'd4;
    localparam t_mode MODE_ELU      = 5'd5;
    localparam t_mode MODE_SELU     = 5'd6;
    localparam t_mode MODE_RELIE    = 5'd7;
    localparam t_mode MODE_RAMP     = 5'd8;
    localparam t_mode MODE_LEAKY    = 5'd9;
    localparam t_mode MODE_TANH     = 5'd10;
    localparam t_mode MODE_PLSE     = 5'd11;
    localparam t_mode MODE_STAIR    = 5'd12;
    localparam t_mode MODE_HARDTAN  = 5'd13;
    localparam t_mode MODE_LHTAN    = 5'd14;
    localparam t_mode MODE_REVLEAKY = 5'd15;
    localparam t_mode MODE_NORMCHAN = 5'd16;

    localparam logic ACT_FORWARD  = 1'b0;
    localparam logic ACT_GRADIENT = 1'b1;

    localparam logic signed [31:0] Q_ONE        = 32'sd65536;
    localparam logic signed [31:0] K_001        = 32'sd66;
    localparam logic signed [31:0] K_01         = 32'sd655;
    localparam logic signed [31:0] K_1          = 32'sd6554;
    localparam logic signed [31:0] K_125        = 32'sd8192;
    localparam logic signed [31:0] K_HALF       = 32'sd32768;
    localparam logic signed [31:0] K_SIX        = 32'sd393216;
    localparam logic signed [31:0] K_FOUR       = 32'sd262144;
    localparam logic signed [31:0] K_TEN        = 32'sd655360;
    localparam logic signed [31:0] K_SELU_SCALE = 32'sd68858;
    localparam logic signed [31:0] K_SELU_NEG   = 32'sd115214;

    typedef struct packed {
        logic               action;
        logic signed [31:0] value;
        logic signed [31:0] delta;
        logic               last_item;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] result;
        logic               unsupported;
        logic               last_out;
    } t_out_item;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -66'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// File: design/activation_and_gradient_unit_core.sv
// Top level: pipelined Q16.16 activation and gradient unit.
`timescale 1ns / 1ps

// Usage:
//   Input channel: drive i_item and pulse i_start; a transaction is taken at
//   every rising edge with i_start high and o_busy low. o_busy is always low,
//   so one transaction can enter every cycle.
//   Output channel: each result appears on o_item for exactly one cycle with
//   o_valid high, driven from the output register. Results leave in input
//   order. The receiver cannot stall the block.
//   Configuration: i_cfg_we with i_cfg_wdata writes the 5-bit mode register;
//   write it only while no transaction is in flight.
//   Pipeline: input register, operand setup, first multiply (gradient
//   factor for logistic, loggy and tanh), factor and operand select, second
//   multiply, shift, offset and saturate into the output register. The two
//   multipliers set the depth; throughput is one transaction per cycle.
//   Reset (synchronous, active low) clears all stage valid bits and sets the
//   mode to linear; no result is lost or repeated across a stall-free flow.
module activation_and_gradient_unit_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  agu_pkg::t_in_item   i_item,
    output logic                o_valid,
    output agu_pkg::t_out_item  o_item,
    input  logic                i_cfg_we,
    input  logic [4:0]          i_cfg_wdata
);
    import agu_pkg::*;

    t_mode r_mode;

    logic               r_v0, r_v1, r_v2, r_v3, r_v4, r_v5;
    t_in_item           r_s0;
    t_in_item           r_s1;
    t_in_item           r_s2;
    logic signed [32:0] r_m1a;
    logic signed [31:0] r_m1b;
    logic signed [64:0] r_p1;
    logic signed [32:0] r_a;
    logic signed [31:0] r_g;
    logic signed [31:0] r_b3;
    logic               r_unsup3, r_last3;
    logic signed [64:0] r_p2;
    logic signed [31:0] r_b4;
    logic               r_unsup4, r_last4;
    t_out_item          r_out;

    logic signed [31:0] n_m1b;
    logic signed [32:0] n_m1a;
    logic signed [31:0] s0_x;
    logic signed [32:0] s0_xe;
    logic signed [31:0] s0_y;

    logic signed [31:0] n_g;
    logic signed [32:0] n_a;
    logic signed [31:0] n_b;
    logic               n_unsup;
    logic signed [31:0] x;
    logic signed [32:0] xe;
    logic               x_pos, x_neg;
    logic signed [31:0] stair;
    logic signed [65:0] p1_shr;

    logic signed [65:0] sum5;

    assign o_busy  = 1'b0;
    assign o_valid = r_v5;
    assign o_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_LINEAR;
            r_v0   <= 1'b0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_v4   <= 1'b0;
            r_v5   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            r_v0 <= i_start && !o_busy;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_comb begin
        s0_x  = r_s0.value;
        s0_xe = 33'(s0_x);
        s0_y  = 32'((s0_xe + 33'(Q_ONE)) >>> 1);
        n_m1a = '0;
        n_m1b = '0;
        unique case (r_mode) inside
            MODE_LOGISTIC: begin
                n_m1a = 33'(Q_ONE) - s0_xe;
                n_m1b = s0_x;
            end
            MODE_LOGGY: begin
                n_m1a = 33'(Q_ONE) - 33'(s0_y);
                n_m1b = s0_y;
            end
            MODE_TANH: begin
                n_m1a = s0_xe;
                n_m1b = s0_x;
            end
            default: begin
                n_m1a = '0;
                n_m1b = '0;
            end
        endcase
    end

    always_comb begin
        x      = r_s2.value;
        xe     = 33'(x);
        x_pos  = (x > 32'sd0);
        x_neg  = x[31];
        stair  = {x[31], x[31:17], (x[16] ? x[15:0] : 16'h0000)};
        p1_shr = 66'(r_p1 >>> 16);
        n_a    = xe;
        n_g    = Q_ONE;
        n_b    = '0;
        n_unsup = 1'b0;
        if (r_s2.action == ACT_FORWARD) begin
            unique case (r_mode) inside
                MODE_LINEAR: begin
                    n_g = Q_ONE;
                end
                MODE_LOGISTIC, MODE_LOGGY, MODE_ELU, MODE_SELU, MODE_TANH: begin
                    n_a     = '0;
                    n_g     = '0;
                    n_unsup = 1'b1;
                end
                MODE_RELU: begin
                    n_a = x_pos ? xe : 33'sd0;
                end
                MODE_RELU6: begin
                    n_a = x_neg ? 33'sd0 : ((x > K_SIX) ? 33'(K_SIX) : xe);
                end
                MODE_RELIE: begin
                    n_g = x_pos ? Q_ONE : K_01;
                end
                MODE_RAMP: begin
                    n_g = x_pos ? (Q_ONE + K_1) : K_1;
                end
                MODE_LEAKY: begin
                    n_g = x_pos ? Q_ONE : K_1;
                end
                MODE_PLSE: begin
                    if (x < -K_FOUR) begin
                        n_a = xe + 33'(K_FOUR);
                        n_g = K_01;
                    end else if (x > K_FOUR) begin
                        n_a = xe - 33'(K_FOUR);
                        n_g = K_01;
                        n_b = Q_ONE;
                    end else begin
                        n_g = K_125;
                        n_b = K_HALF;
                    end
                end
                MODE_STAIR: begin
                    n_a = 33'(stair);
                end
                MODE_HARDTAN: begin
                    n_a = (x < -Q_ONE) ? -33'(Q_ONE) : ((x > Q_ONE) ? 33'(Q_ONE) : xe);
                end
                MODE_LHTAN: begin
                    if (x_neg) begin
                        n_g = K_001;
                    end else if (x > Q_ONE) begin
                        n_a = xe - 33'(Q_ONE);
                        n_g = K_001;
                        n_b = Q_ONE;
                    end
                end
                default: begin
                    n_a = '0;
                    n_g = '0;
                end
            endcase
        end else begin
            n_a = 33'(r_s2.delta);
            unique case (r_mode) inside
                MODE_LINEAR:   n_g = Q_ONE;
                MODE_LOGISTIC: n_g = sat32(p1_shr);
                MODE_LOGGY:    n_g = sat32(p1_shr <<< 1);
                MODE_RELU, MODE_NORMCHAN: n_g = x_pos ? Q_ONE : 32'sd0;
                MODE_RELU6:    n_g = (x_pos && (x < K_SIX)) ? Q_ONE : 32'sd0;
                MODE_ELU:      n_g = x_neg ? 32'(xe + 33'(Q_ONE)) : Q_ONE;
                MODE_SELU:     n_g = x_neg ? 32'(xe + 33'(K_SELU_NEG)) : K_SELU_SCALE;
                MODE_RELIE:    n_g = x_pos ? Q_ONE : K_01;
                MODE_RAMP:     n_g = x_pos ? (Q_ONE + K_1) : K_1;
                MODE_LEAKY:    n_g = x_pos ? Q_ONE : K_1;
                MODE_TANH:     n_g = sat32(66'(Q_ONE) - p1_shr);
                MODE_PLSE:     n_g = (x_neg || (x > Q_ONE)) ? K_01 : K_125;
                MODE_STAIR:    n_g = (x[15:0] == 16'h0000) ? 32'sd0 : Q_ONE;
                MODE_HARDTAN:  n_g = ((x > -Q_ONE) && (x < Q_ONE)) ? Q_ONE : 32'sd0;
                MODE_LHTAN:    n_g = (x_pos && (x < Q_ONE)) ? Q_ONE : K_001;
                MODE_REVLEAKY: n_g = x_pos ? Q_ONE : K_TEN;
                default:       n_g = '0;
            endcase
        end
    end

    assign sum5 = 66'(r_p2 >>> 16) + 66'(r_b4);

    always_ff @(posedge i_clk) begin
        r_s0 <= i_item;

        r_s1  <= r_s0;
        r_m1a <= n_m1a;
        r_m1b <= n_m1b;

        r_s2 <= r_s1;
        r_p1 <= 65'(r_m1a) * 65'(r_m1b);

        r_a      <= n_a;
        r_g      <= n_g;
        r_b3     <= n_b;
        r_unsup3 <= n_unsup;
        r_last3  <= r_s2.last_item;

        r_p2     <= 65'(r_a) * 65'(r_g);
        r_b4     <= r_b3;
        r_unsup4 <= r_unsup3;
        r_last4  <= r_last3;

        r_out.result      <= sat32(sum5);
        r_out.unsupported <= r_unsup4;
        r_out.last_out    <= r_last4;
    end

endmodule

// File: design/agu_checker.sv
// Checker: port-level assertions for the activation unit, bound to the top level.
`timescale 1ns / 1ps

module agu_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_start,
    input logic                o_busy,
    input agu_pkg::t_in_item   i_item,
    input logic                o_valid,
    input agu_pkg::t_out_item  o_item
);
    import agu_pkg::*;

    a_accept_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##6 o_valid)
        else $error("accepted transaction produced no result");

    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start && !o_busy, 6))
        else $error("result without a matching transaction");

    a_last_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_item.last_out == $past(i_item.last_item, 6)))
        else $error("last flag does not follow its transaction");

    a_unsup_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.unsupported) |-> (o_item.result == 32'sd0))
        else $error("unsupported result is not zero");

    a_unsup_forward: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.unsupported) |-> ($past(i_item.action, 6) == ACT_FORWARD))
        else $error("unsupported flag on a gradient transaction");

endmodule

bind activation_and_gradient_unit_core agu_checker u_agu_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .o_busy  (o_busy),
    .i_item  (i_item),
    .o_valid (o_valid),
    .o_item  (o_item)
);

// File: dv/tb_activation_and_gradient_unit_core.sv
// Testbench: checks the activation and gradient unit against a Q16.16 predictor in every mode.
`timescale 1ns / 1ps

module tb_activation_and_gradient_unit_core;

    import agu_pkg::*;

    localparam int     PIPE_LATENCY   = 6;
    localparam int     WATCHDOG_LIMIT = 2000;
    localparam t_mode  MODE_UNUSED_LO = MODE_NORMCHAN + 5'd1;
    localparam t_mode  MODE_UNUSED_HI = 5'd31;
    localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] Q_MIN = 32'sh80000000;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_start;
    logic       o_busy;
    t_in_item   i_item;
    logic       o_valid;
    t_out_item  o_item;
    logic       i_cfg_we;
    t_mode      i_cfg_wdata;

    t_out_item  expected_q[$];
    t_mode      mode_shadow;
    int         gap_pct;
    int         error_count;
    int         items_sent;
    int         results_seen;
    int         mode_writes;
    int         idle_cycles;

    activation_and_gradient_unit_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .o_item      (o_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint clamp_q32(input longint v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint fx_mul(input longint a, input longint b);
        return clamp_q32((a * b) >>> 16);
    endfunction

    function automatic t_out_item predict_activation(input t_mode m, input t_in_item it);
        logic [31:0] raw;
        longint      x;
        longint      d;
        longint      g;
        longint      y;
        longint      r;
        logic        unsup;
        t_out_item   o;
        raw   = it.value;
        x     = longint'($signed(raw));
        d     = longint'($signed(it.delta));
        unsup = 1'b0;
        g     = 0;
        if (it.action == ACT_FORWARD) begin
            case (m)
                MODE_LINEAR: r = x;
                MODE_LOGISTIC, MODE_LOGGY, MODE_ELU, MODE_SELU, MODE_TANH: begin
                    unsup = 1'b1;
                    r = 0;
                end
                MODE_RELU:   r = (x > 0) ? x : 0;
                MODE_RELU6:  r = (x < 0) ? 0 : ((x > K_SIX) ? K_SIX : x);
                MODE_RELIE:  r = (x > 0) ? x : fx_mul(x, K_01);
                MODE_RAMP:   r = clamp_q32(((x > 0) ? x : 0) + ((x * K_1) >>> 16));
                MODE_LEAKY:  r = (x > 0) ? x : fx_mul(x, K_1);
                MODE_PLSE: begin
                    if (x < -K_FOUR) begin
                        r = fx_mul(x + K_FOUR, K_01);
                    end else if (x > K_FOUR) begin
                        r = clamp_q32((((x - K_FOUR) * K_01) >>> 16) + Q_ONE);
                    end else begin
                        r = clamp_q32(((x * K_125) >>> 16) + K_HALF);
                    end
                end
                MODE_STAIR: begin
                    y = (x >>> 17) * Q_ONE;
                    r = raw[16] ? clamp_q32(longint'(raw[15:0]) + y) : y;
                end
                MODE_HARDTAN: r = (x < -Q_ONE) ? -Q_ONE : ((x > Q_ONE) ? Q_ONE : x);
                MODE_LHTAN: begin
                    if (x < 0) begin
                        r = fx_mul(x, K_001);
                    end else if (x > Q_ONE) begin
                        r = clamp_q32((((x - Q_ONE) * K_001) >>> 16) + Q_ONE);
                    end else begin
                        r = x;
                    end
                end
                default: r = 0;
            endcase
        end else begin
            case (m)
                MODE_LOGISTIC: g = clamp_q32(((Q_ONE - x) * x) >>> 16);
                MODE_LOGGY: begin
                    y = (x + Q_ONE) >>> 1;
                    g = clamp_q32(2 * (((Q_ONE - y) * y) >>> 16));
                end
                MODE_RELU, MODE_NORMCHAN: g = (x > 0) ? Q_ONE : 0;
                MODE_RELU6:   g = (x > 0 && x < K_SIX) ? Q_ONE : 0;
                MODE_ELU:     g = (x >= 0) ? Q_ONE : clamp_q32(x + Q_ONE);
                MODE_SELU:    g = (x >= 0) ? K_SELU_SCALE : clamp_q32(x + K_SELU_NEG);
                MODE_RELIE:   g = (x > 0) ? Q_ONE : K_01;
                MODE_RAMP:    g = (x > 0) ? (Q_ONE + K_1) : K_1;
                MODE_LEAKY:   g = (x > 0) ? Q_ONE : K_1;
                MODE_TANH:    g = clamp_q32(Q_ONE - ((x * x) >>> 16));
                MODE_PLSE:    g = (x < 0 || x > Q_ONE) ? K_01 : K_125;
                MODE_STAIR:   g = (raw[15:0] == 16'd0) ? 0 : Q_ONE;
                MODE_HARDTAN: g = (x > -Q_ONE && x < Q_ONE) ? Q_ONE : 0;
                MODE_LHTAN:   g = (x > 0 && x < Q_ONE) ? Q_ONE : K_001;
                default:      g = 0;
            endcase
            case (m)
                MODE_LINEAR:   r = d;
                MODE_REVLEAKY: r = (x > 0) ? d : clamp_q32(d * 10);
                default:       r = fx_mul(d, g);
            endcase
        end
        o.result      = r[31:0];
        o.unsupported = unsup;
        o.last_out    = it.last_item;
        return o;
    endfunction

    function automatic t_in_item make_item(input logic act, input logic signed [31:0] v,
                                           input logic signed [31:0] d, input logic last);
        t_in_item it;
        it.action    = act;
        it.value     = v;
        it.delta     = d;
        it.last_item = last;
        return it;
    endfunction

    function automatic logic signed [31:0] pick_q16();
        logic signed [31:0] v;
        case ($urandom_range(0, 6))
            0: v = $signed($urandom_range(0, 32'h00100000)) - 32'sh00080000;
            1: begin
                case ($urandom_range(0, 6))
                    0: v = 0;
                    1: v = Q_ONE;
                    2: v = -Q_ONE;
                    3: v = K_SIX;
                    4: v = K_FOUR;
                    5: v = -K_FOUR;
                    default: v = Q_ONE >>> 1;
                endcase
                v = v + $signed($urandom_range(0, 4)) - 2;
            end
            2: v = $urandom_range(0, 1) ? Q_MAX - $urandom_range(0, 2)
                                        : Q_MIN + $urandom_range(0, 2);
            3: v = {16'($urandom_range(0, 16'hffff)), 16'h0000};
            4: v = $signed($urandom_range(0, 32'h01000000)) - 32'sh00800000;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic t_in_item random_item();
        return make_item(1'($urandom_range(0, 1)), pick_q16(), pick_q16(),
                         1'($urandom_range(0, 1)));
    endfunction

    task automatic send_item(input t_in_item it);
        i_item  <= it;
        i_start <= 1'b1;
        do @(posedge i_clk); while (o_busy);
        expected_q.push_back(predict_activation(mode_shadow, it));
        items_sent++;
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_start <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY) @(posedge i_clk);
    endtask

    task automatic write_mode(input t_mode m);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        mode_shadow = m;
        mode_writes++;
    endtask

    task automatic test_special_cases();
        gap_pct = 20;
        send_item(make_item(ACT_FORWARD, Q_MAX, 0, 1'b0));
        send_item(make_item(ACT_FORWARD, Q_MIN, Q_MAX, 1'b1));
        send_item(make_item(ACT_GRADIENT, 32'sh00012345, Q_MIN, 1'b0));
        write_mode(MODE_LOGISTIC);
        send_item(make_item(ACT_FORWARD, 32'sh00003039, 0, 1'b1));
        send_item(make_item(ACT_GRADIENT, Q_MIN, Q_MAX, 1'b0));
        write_mode(MODE_TANH);
        send_item(make_item(ACT_GRADIENT, Q_MAX, Q_MIN, 1'b1));
        write_mode(MODE_STAIR);
        send_item(make_item(ACT_FORWARD, 32'sh00031234, 0, 1'b0));
        send_item(make_item(ACT_FORWARD, 32'sh00028000, 0, 1'b1));
        send_item(make_item(ACT_FORWARD, -32'sh00008000, 0, 1'b0));
        send_item(make_item(ACT_GRADIENT, 32'sh00050000, Q_MAX, 1'b1));
        write_mode(MODE_REVLEAKY);
        send_item(make_item(ACT_FORWARD, 32'sd5, 0, 1'b0));
        send_item(make_item(ACT_GRADIENT, 0, Q_MAX, 1'b1));
        send_item(make_item(ACT_GRADIENT, 32'sd1, Q_MIN, 1'b0));
        send_item(make_item(ACT_GRADIENT, -32'sd1, Q_MIN, 1'b1));
        write_mode(MODE_NORMCHAN);
        send_item(make_item(ACT_FORWARD, Q_ONE, 0, 1'b0));
        send_item(make_item(ACT_GRADIENT, 32'sd1, 32'sh00020000, 1'b1));
        write_mode(MODE_PLSE);
        send_item(make_item(ACT_FORWARD, -K_FOUR - 1, 0, 1'b0));
        send_item(make_item(ACT_FORWARD, K_FOUR + 1, 0, 1'b1));
        send_item(make_item(ACT_FORWARD, Q_MAX, 0, 1'b0));
        write_mode(MODE_UNUSED_LO);
        send_item(make_item(ACT_FORWARD, Q_ONE, Q_ONE, 1'b1));
        write_mode(MODE_UNUSED_HI);
        send_item(make_item(ACT_FORWARD, -Q_ONE, Q_ONE, 1'b0));
        send_item(make_item(ACT_GRADIENT, Q_ONE, Q_MAX, 1'b1));
    endtask

    task automatic test_random_modes();
        int p;
        int n;
        for (p = 0; p < 32; p++) begin
            write_mode(t_mode'(p));
            case ($urandom_range(0, 2))
                0: gap_pct = 0;
                1: gap_pct = 10;
                default: gap_pct = 35;
            endcase
            for (n = 0; n < 24; n++) begin
                if (p == 8 && n == 12) begin
                    wait_drained();
                end
                send_item(random_item());
            end
        end
    endtask

    task automatic test_back_to_back();
        int n;
        write_mode(t_mode'($urandom_range(0, 31)));
        gap_pct = 0;
        for (n = 0; n < 130; n++) begin
            send_item(random_item());
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual %h", $time, o_item);
                error_count++;
            end else begin
                want = expected_q.pop_front();
                results_seen++;
                if (o_item.result !== want.result) begin
                    $display("%0t: result mismatch: expected %h, actual %h",
                             $time, want.result, o_item.result);
                    error_count++;
                end
                if (o_item.unsupported !== want.unsupported) begin
                    $display("%0t: unsupported mismatch: expected %b, actual %b",
                             $time, want.unsupported, o_item.unsupported);
                    error_count++;
                end
                if (o_item.last_out !== want.last_out) begin
                    $display("%0t: last_out mismatch: expected %b, actual %b",
                             $time, want.last_out, o_item.last_out);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_start      = 1'b0;
        i_item       = '0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = MODE_LINEAR;
        mode_shadow  = MODE_LINEAR;
        gap_pct      = 0;
        error_count  = 0;
        items_sent   = 0;
        results_seen = 0;
        mode_writes  = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_special_cases();
        test_random_modes();
        test_back_to_back();

        wait_drained();
        repeat (PIPE_LATENCY + 4) @(posedge i_clk);
        if (expected_q.size() != 0) begin
            $display("%0t: missing results: expected %0d more, actual 0",
                     $time, expected_q.size());
            error_count++;
        end
        $display("Sent %0d transactions through %0d mode writes covering all 32 mode codes;",
                 items_sent, mode_writes);
        $display("checked %0d results in forward and gradient paths, %0d errors.",
                 results_seen, error_count);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: files.f
design/agu_pkg.sv
design/activation_and_gradient_unit_core.sv
design/agu_checker.sv
dv/tb_activation_and_gradient_unit_core.sv
